// ===== sv/tfs_pkg.sv =====
// Shared types, codes and reset values for the thermal fault supervisor.
`timescale 1ns / 1ps

package tfs_pkg;

  // Configuration port geometry
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_MIN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_MAX     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLD_LIMIT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HOT_LIMIT      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HOT_RECOVERY   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CHECK_INTERVAL = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_HOT_CHECK_EN   = 3'd6;

  // Configuration reset values
  localparam logic signed [15:0] RST_SENSOR_MIN     = -16'sd640;
  localparam logic signed [15:0] RST_SENSOR_MAX     = 16'sd1360;
  localparam logic signed [15:0] RST_COLD_LIMIT     = 16'sd640;
  localparam logic signed [15:0] RST_HOT_LIMIT      = 16'sd1120;
  localparam logic signed [15:0] RST_HOT_RECOVERY   = 16'sd800;
  localparam logic [15:0]        RST_CHECK_INTERVAL = 16'd100;
  localparam logic               RST_HOT_CHECK_EN   = 1'b0;

  // Action codes
  localparam logic [2:0] ACT_PERIODIC  = 3'd0;
  localparam logic [2:0] ACT_PRESTART  = 3'd1;
  localparam logic [2:0] ACT_ESTOP     = 3'd2;
  localparam logic [2:0] ACT_RAMP_TMO  = 3'd3;
  localparam logic [2:0] ACT_ACK       = 3'd4;

  // Error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_SENSOR    = 3'd1;
  localparam logic [2:0] ERR_INVALID   = 3'd2;
  localparam logic [2:0] ERR_COLD_OVER = 3'd3;
  localparam logic [2:0] ERR_HOT_OVER  = 3'd4;
  localparam logic [2:0] ERR_RAMP_TMO  = 3'd5;
  localparam logic [2:0] ERR_ESTOP     = 3'd6;

  // State commands
  localparam logic [1:0] CMD_NONE    = 2'd0;
  localparam logic [1:0] CMD_FAULT   = 2'd1;
  localparam logic [1:0] CMD_STOPPED = 2'd2;
  localparam logic [1:0] CMD_IDLE    = 2'd3;

  // Sensor flag codes
  localparam logic [1:0] SFLAG_NONE    = 2'd0;
  localparam logic [1:0] SFLAG_INVALID = 2'd1;
  localparam logic [1:0] SFLAG_VALID   = 2'd2;

  // Announcement codes
  localparam logic [1:0] ANN_NONE   = 2'd0;
  localparam logic [1:0] ANN_SENSOR = 2'd1;
  localparam logic [1:0] ANN_OVER   = 2'd2;
  localparam logic [1:0] ANN_ESTOP  = 2'd3;

  typedef struct packed {
    logic signed [15:0] sensor_min;
    logic signed [15:0] sensor_max;
    logic signed [15:0] cold_limit;
    logic signed [15:0] hot_limit;
    logic signed [15:0] hot_recovery;
    logic [15:0]        check_interval;
    logic               hot_check_enable;
  } cfg_t;

  typedef struct packed {
    logic [2:0]         action;
    logic [31:0]        now_ms;
    logic               cold_valid;
    logic signed [15:0] cold_temp;
    logic               hot_valid;
    logic signed [15:0] hot_temp;
    logic               operating;
    logic               drive_active;
  } item_t;

  typedef struct packed {
    logic       ok;
    logic [2:0] latched_error;
    logic [2:0] reported_error;
    logic [1:0] state_command;
    logic       outputs_off;
    logic [1:0] sensor_flag;
    logic [1:0] announce;
    logic       acknowledged;
    logic       hot_recorded;
  } result_t;

endpackage

// ===== sv/tfs_if.sv =====
// Command and result channel interfaces of the thermal fault supervisor.
`timescale 1ns / 1ps

interface tfs_cmd_if;
  logic               valid;
  logic               ready;
  logic [2:0]         action;
  logic [31:0]        now_ms;
  logic               cold_valid;
  logic signed [15:0] cold_temp;
  logic               hot_valid;
  logic signed [15:0] hot_temp;
  logic               operating;
  logic               drive_active;

  modport source (
    output valid, action, now_ms, cold_valid, cold_temp, hot_valid, hot_temp,
           operating, drive_active,
    input  ready
  );
  modport sink (
    input  valid, action, now_ms, cold_valid, cold_temp, hot_valid, hot_temp,
           operating, drive_active,
    output ready
  );
endinterface

interface tfs_res_if;
  logic       valid;
  logic       ready;
  logic       ok;
  logic [2:0] latched_error;
  logic [2:0] reported_error;
  logic [1:0] state_command;
  logic       outputs_off;
  logic [1:0] sensor_flag;
  logic [1:0] announce;
  logic       acknowledged;
  logic       hot_recorded;

  modport source (
    output valid, ok, latched_error, reported_error, state_command, outputs_off,
           sensor_flag, announce, acknowledged, hot_recorded,
    input  ready
  );
  modport sink (
    input  valid, ok, latched_error, reported_error, state_command, outputs_off,
           sensor_flag, announce, acknowledged, hot_recorded,
    output ready
  );
endinterface

// ===== sv/tfs_cfg_regs.sv =====
// Configuration register bank of the thermal fault supervisor.
`timescale 1ns / 1ps

module tfs_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [tfs_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [tfs_pkg::CFG_DATA_W-1:0] wr_data,
  output tfs_pkg::cfg_t                  cfg
);

  // Load reset values, then take writes by index
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sensor_min       <= tfs_pkg::RST_SENSOR_MIN;
      cfg.sensor_max       <= tfs_pkg::RST_SENSOR_MAX;
      cfg.cold_limit       <= tfs_pkg::RST_COLD_LIMIT;
      cfg.hot_limit        <= tfs_pkg::RST_HOT_LIMIT;
      cfg.hot_recovery     <= tfs_pkg::RST_HOT_RECOVERY;
      cfg.check_interval   <= tfs_pkg::RST_CHECK_INTERVAL;
      cfg.hot_check_enable <= tfs_pkg::RST_HOT_CHECK_EN;
    end else if (wr_en) begin
      unique case (wr_index)
        tfs_pkg::CFG_SENSOR_MIN:     cfg.sensor_min       <= wr_data;
        tfs_pkg::CFG_SENSOR_MAX:     cfg.sensor_max       <= wr_data;
        tfs_pkg::CFG_COLD_LIMIT:     cfg.cold_limit       <= wr_data;
        tfs_pkg::CFG_HOT_LIMIT:      cfg.hot_limit        <= wr_data;
        tfs_pkg::CFG_HOT_RECOVERY:   cfg.hot_recovery     <= wr_data;
        tfs_pkg::CFG_CHECK_INTERVAL: cfg.check_interval   <= wr_data;
        tfs_pkg::CFG_HOT_CHECK_EN:   cfg.hot_check_enable <= wr_data[0];
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/tfs_eval.sv =====
// Decision logic and supervisor state: one action evaluated per cycle while fire is high.
`timescale 1ns / 1ps

module tfs_eval (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  tfs_pkg::item_t    item,
  input  tfs_pkg::cfg_t     cfg,
  output tfs_pkg::result_t  res
);

  logic [2:0]         latch;
  logic               ack;
  logic [31:0]        last_check;
  logic signed [15:0] last_hot;

  logic [2:0]         latch_next;
  logic               ack_next;
  logic [31:0]        last_check_next;
  logic signed [15:0] last_hot_next;

  logic [31:0] elapsed;
  logic        interval_due;
  logic        cold_out_of_range;
  logic        cold_over;
  logic        hot_over;
  logic        fault_hit;
  logic [2:0]  fault_code;
  logic        rep_set;
  logic [2:0]  rep_code;

  // Map a fault code to its announcement
  function automatic logic [1:0] announce_of(input logic [2:0] code);
    logic [1:0] a;
    if (code == tfs_pkg::ERR_SENSOR || code == tfs_pkg::ERR_INVALID) begin
      a = tfs_pkg::ANN_SENSOR;
    end else if (code == tfs_pkg::ERR_COLD_OVER || code == tfs_pkg::ERR_HOT_OVER) begin
      a = tfs_pkg::ANN_OVER;
    end else begin
      a = tfs_pkg::ANN_NONE;
    end
    return a;
  endfunction

  // Shared comparisons
  assign elapsed           = item.now_ms - last_check;
  assign interval_due      = !(elapsed < {16'd0, cfg.check_interval});
  assign cold_out_of_range = (item.cold_temp < cfg.sensor_min) ||
                             (item.cold_temp > cfg.sensor_max);
  assign cold_over         = item.cold_temp > cfg.cold_limit;
  assign hot_over          = item.hot_temp > cfg.hot_limit;

  // Evaluate the action against the current state
  always_comb begin
    res             = '0;
    latch_next      = latch;
    ack_next        = ack;
    last_check_next = last_check;
    last_hot_next   = last_hot;
    fault_hit       = 1'b0;
    fault_code      = tfs_pkg::ERR_NONE;
    rep_set         = 1'b0;
    rep_code        = tfs_pkg::ERR_NONE;

    unique case (item.action)
      tfs_pkg::ACT_PERIODIC: begin
        if (!interval_due) begin
          res.ok = (latch == tfs_pkg::ERR_NONE);
        end else begin
          last_check_next = item.now_ms;
          priority if (!item.cold_valid && item.operating) begin
            fault_hit  = 1'b1;
            fault_code = tfs_pkg::ERR_SENSOR;
          end else begin
            res.sensor_flag = item.cold_valid ? tfs_pkg::SFLAG_VALID
                                              : tfs_pkg::SFLAG_INVALID;
            priority if (cold_out_of_range && item.drive_active) begin
              fault_hit  = 1'b1;
              fault_code = tfs_pkg::ERR_INVALID;
            end else if (cold_over && item.drive_active) begin
              fault_hit  = 1'b1;
              fault_code = tfs_pkg::ERR_COLD_OVER;
            end else if (cfg.hot_check_enable && item.hot_valid) begin
              // Record the hot reading before it is judged
              last_hot_next    = item.hot_temp;
              res.hot_recorded = 1'b1;
              if (hot_over) begin
                fault_hit  = 1'b1;
                fault_code = tfs_pkg::ERR_HOT_OVER;
              end else begin
                res.ok = 1'b1;
              end
            end else begin
              res.ok = 1'b1;
            end
          end
        end
      end
      tfs_pkg::ACT_PRESTART: begin
        rep_set = 1'b1;
        priority if (!item.cold_valid) begin
          rep_code = tfs_pkg::ERR_SENSOR;
        end else if (cold_out_of_range) begin
          rep_code = tfs_pkg::ERR_INVALID;
        end else begin
          latch_next = tfs_pkg::ERR_NONE;
          ack_next   = 1'b0;
          res.ok     = 1'b1;
        end
      end
      tfs_pkg::ACT_ESTOP: begin
        latch_next        = tfs_pkg::ERR_ESTOP;
        ack_next          = 1'b0;
        rep_set           = 1'b1;
        rep_code          = tfs_pkg::ERR_ESTOP;
        res.state_command = tfs_pkg::CMD_STOPPED;
        res.outputs_off   = 1'b1;
        res.announce      = tfs_pkg::ANN_ESTOP;
        res.ok            = 1'b1;
      end
      tfs_pkg::ACT_RAMP_TMO: begin
        fault_hit  = 1'b1;
        fault_code = tfs_pkg::ERR_RAMP_TMO;
        res.ok     = 1'b1;
      end
      tfs_pkg::ACT_ACK: begin
        priority if (latch == tfs_pkg::ERR_NONE) begin
          res.ok = 1'b1;
        end else if (cfg.hot_check_enable && latch == tfs_pkg::ERR_HOT_OVER &&
                     last_hot > cfg.hot_recovery) begin
          // Refuse while the hot side is still above recovery
          res.ok = 1'b0;
        end else begin
          ack_next          = 1'b1;
          latch_next        = tfs_pkg::ERR_NONE;
          rep_set           = 1'b1;
          rep_code          = tfs_pkg::ERR_NONE;
          res.state_command = tfs_pkg::CMD_IDLE;
          res.ok            = 1'b1;
        end
      end
      default: ;
    endcase

    // Apply a latched fault
    if (fault_hit) begin
      latch_next        = fault_code;
      ack_next          = 1'b0;
      rep_set           = 1'b1;
      rep_code          = fault_code;
      res.state_command = tfs_pkg::CMD_FAULT;
      res.outputs_off   = 1'b1;
      res.announce      = announce_of(fault_code);
    end

    res.reported_error = rep_set ? rep_code : latch_next;
    res.latched_error  = latch_next;
    res.acknowledged   = ack_next;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      latch      <= tfs_pkg::ERR_NONE;
      ack        <= 1'b0;
      last_check <= '0;
      last_hot   <= '0;
    end else if (fire) begin
      latch      <= latch_next;
      ack        <= ack_next;
      last_check <= last_check_next;
      last_hot   <= last_hot_next;
    end
  end

  // An acknowledged fault always leaves the latch clear
  a_ack_clear: assert property (@(posedge clk) disable iff (rst)
    ack |-> latch == tfs_pkg::ERR_NONE)
    else $error("acknowledge flag set with an error latched");

  // An emergency stop always latches its code
  a_estop_latch: assert property (@(posedge clk) disable iff (rst)
    fire && item.action == tfs_pkg::ACT_ESTOP |=> latch == tfs_pkg::ERR_ESTOP)
    else $error("emergency stop did not latch");

  // Hold state while no beat is evaluated
  a_hold_state: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(latch) && $stable(ack) && $stable(last_check))
    else $error("supervisor state moved without a beat");

  // Forcing outputs off always comes with a state change
  a_off_cmd: assert property (@(posedge clk) disable iff (rst)
    fire && res.outputs_off |->
      res.state_command == tfs_pkg::CMD_FAULT ||
      res.state_command == tfs_pkg::CMD_STOPPED)
    else $error("outputs forced off without a fault or stop command");

endmodule

// ===== sv/thermal_fault_supervisor_top.sv =====
// Top level of the thermal fault supervisor: input stage, evaluation, result stage.
//
//   Channel   Dir  Handshake       Payload
//   cmd       in   valid/ready     action, now_ms, sensor readings, flags
//   res       out  valid/ready     ok, error codes, commands, flags
//   wr_*      in   wr_en only      wr_index, wr_data (16 bits)
//
// One beat is taken per cycle while the result channel is not stalled. A command
// beat is captured in the input register, one pass of compare logic loads the
// result register from it, and the result beat is then offered on the res channel.
// The supervisor state updates as a beat leaves the input register, so the next
// beat always sees it. Reset is synchronous, clears both valid flags and the state,
// and loads the configuration reset values. A stalled result holds its register;
// the input register keeps accepting as long as its contents can move on in the
// same cycle.
`timescale 1ns / 1ps

module thermal_fault_supervisor_top (
  input  logic                           clk,
  input  logic                           rst,
  tfs_cmd_if.sink                        cmd,
  tfs_res_if.source                      res,
  input  logic                           wr_en,
  input  logic [tfs_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [tfs_pkg::CFG_DATA_W-1:0] wr_data
);

  tfs_pkg::cfg_t    cfg;
  tfs_pkg::item_t   item_in;
  tfs_pkg::item_t   item;
  logic             item_valid;
  logic             advance;
  tfs_pkg::result_t result_next;
  tfs_pkg::result_t result;
  logic             result_valid;

  tfs_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  // Pack the incoming beat
  always_comb begin
    item_in.action       = cmd.action;
    item_in.now_ms       = cmd.now_ms;
    item_in.cold_valid   = cmd.cold_valid;
    item_in.cold_temp    = cmd.cold_temp;
    item_in.hot_valid    = cmd.hot_valid;
    item_in.hot_temp     = cmd.hot_temp;
    item_in.operating    = cmd.operating;
    item_in.drive_active = cmd.drive_active;
  end

  // Advance when the result register is free or being drained
  assign advance   = item_valid && (!result_valid || res.ready);
  assign cmd.ready = !item_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (cmd.ready) begin
      item_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ready && cmd.valid) begin
      item <= item_in;
    end
  end

  tfs_eval u_eval (
    .clk  (clk),
    .rst  (rst),
    .fire (advance),
    .item (item),
    .cfg  (cfg),
    .res  (result_next)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (res.ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

  // Drive the result channel
  assign res.valid          = result_valid;
  assign res.ok             = result.ok;
  assign res.latched_error  = result.latched_error;
  assign res.reported_error = result.reported_error;
  assign res.state_command  = result.state_command;
  assign res.outputs_off    = result.outputs_off;
  assign res.sensor_flag    = result.sensor_flag;
  assign res.announce       = result.announce;
  assign res.acknowledged   = result.acknowledged;
  assign res.hot_recorded   = result.hot_recorded;

endmodule
